// ----- hw/rtl/jpc_pkg.sv -----
// shared constants, types and tables of the joint position collapse block
package jpc_pkg;

  // widths and pipeline sizing
  localparam int VALUE_WIDTH      = 32;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int SHIFT_W          = $clog2(VALUE_WIDTH);
  localparam int NORM_W           = VALUE_WIDTH + 1;
  localparam int CORDIC_W         = VALUE_WIDTH + 3;
  localparam int ANGLE_W          = 34;
  localparam int FRAC_DROP        = 14;
  localparam int SAT_W            = (ANGLE_W > VALUE_WIDTH) ? ANGLE_W : VALUE_WIDTH;
  localparam int NUM_STAGES       = ANGLE_ITERATIONS + 5;
  localparam int LATENCY          = ANGLE_ITERATIONS + 6;

  // joint kind codes
  localparam logic [1:0] KIND_REVOLUTE    = 2'd0;
  localparam logic [1:0] KIND_CONTINUOUS  = 2'd1;
  localparam logic [1:0] KIND_PLANAR      = 2'd2;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

  localparam logic [2:0] MAX_VALUES      = 3'd4;
  localparam logic [2:0] CONTINUOUS_VALS = 3'd1;
  localparam logic [2:0] PLANAR_VALS     = 3'd3;

  // angle constants in q30
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = ANGLE_W'(1686629713);
  localparam logic signed [ANGLE_W-1:0] ROUND_BIAS  = ANGLE_W'(8192);

  // where the angle lands in the result item
  typedef enum logic [1:0] {
    ANG_NONE,
    ANG_TO_A,
    ANG_TO_C
  } ang_dest_e;

  // per-item payload that rides alongside the angle datapath
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] pa;
    logic signed [VALUE_WIDTH-1:0] pb;
    logic signed [VALUE_WIDTH-1:0] pc;
    logic signed [VALUE_WIDTH-1:0] pd;
    logic [2:0]                    count;
    logic                          bad;
    logic                          last;
    logic                          zero;
    ang_dest_e                     dest;
  } side_t;

  // atan(2^-i) in q30, truncated
  function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      5'd24:   v = 32'h0000003F;
      5'd25:   v = 32'h0000001F;
      5'd26:   v = 32'h0000000F;
      5'd27:   v = 32'h00000008;
      5'd28:   v = 32'h00000004;
      5'd29:   v = 32'h00000002;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return ANGLE_W'(v);
  endfunction

  // left shift that brings the top set bit to the msb
  function automatic logic [SHIFT_W-1:0] norm_shift(input logic [VALUE_WIDTH-1:0] m);
    logic [SHIFT_W-1:0] sh;
    sh = '0;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      if (m[i]) begin
        sh = SHIFT_W'(VALUE_WIDTH - 1 - i);
      end
    end
    return sh;
  endfunction

endpackage

// ----- hw/rtl/joint_position_collapse.sv -----
// the result strobe follows acceptance down the valid shift line and then the done register
// throughput: one item per cycle; busy never rises because nothing downstream can stall
// the path holds one cordic stage per iteration plus normalise, rotate and round stages
// reset: rst_ni clears every valid bit and the strobe at once; payload registers keep going
// items in flight at reset are dropped, the first result after reset comes from a new item
module joint_position_collapse
  import jpc_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    joint_kind_i,
  input  logic [2:0]                    dof_count_i,
  input  logic signed [VALUE_WIDTH-1:0] value_a_i,
  input  logic signed [VALUE_WIDTH-1:0] value_b_i,
  input  logic signed [VALUE_WIDTH-1:0] value_c_i,
  input  logic signed [VALUE_WIDTH-1:0] value_d_i,
  input  logic                          last_joint_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] out_a_o,
  output logic signed [VALUE_WIDTH-1:0] out_b_o,
  output logic signed [VALUE_WIDTH-1:0] out_c_o,
  output logic signed [VALUE_WIDTH-1:0] out_d_o,
  output logic [2:0]                    out_count_o,
  output logic                          bad_kind_o,
  output logic                          out_last_o
);

  localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-VALUE_WIDTH+1){1'b0}},
                                                {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO = {{(SAT_W-VALUE_WIDTH+1){1'b1}},
                                                {(VALUE_WIDTH-1){1'b0}}};

  // pipeline is never held, so an item can always enter
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------------
  // entry: decode the joint kind, pick the (cos, sin) pair, build the side item
  // ---------------------------------------------------------------------------
  side_t                         side_d;
  logic signed [VALUE_WIDTH-1:0] x0_d, y0_d;
  logic [2:0]                    dofs;

  always_comb begin
    dofs   = (dof_count_i > MAX_VALUES) ? MAX_VALUES : dof_count_i;
    side_d = '0;
    side_d.last = last_joint_i;
    side_d.dest = ANG_NONE;
    x0_d   = value_a_i;
    y0_d   = value_b_i;
    unique case (joint_kind_i)
      KIND_REVOLUTE: begin
        // pass through only the first dof values, the rest read as zero
        side_d.count = dofs;
        side_d.pa    = (dofs >= 3'd1) ? value_a_i : '0;
        side_d.pb    = (dofs >= 3'd2) ? value_b_i : '0;
        side_d.pc    = (dofs >= 3'd3) ? value_c_i : '0;
        side_d.pd    = (dofs >= 3'd4) ? value_d_i : '0;
      end
      KIND_CONTINUOUS: begin
        side_d.count = CONTINUOUS_VALS;
        side_d.dest  = ANG_TO_A;
      end
      KIND_PLANAR: begin
        side_d.count = PLANAR_VALS;
        side_d.dest  = ANG_TO_C;
        side_d.pa    = value_a_i;
        side_d.pb    = value_b_i;
        x0_d         = value_c_i;
        y0_d         = value_d_i;
      end
      KIND_UNSUPPORTED: begin
        side_d.bad = 1'b1;
      end
      default: begin
        side_d.bad = 1'b1;
      end
    endcase
    // atan2 of the zero vector is defined as zero
    side_d.zero = (x0_d == '0) && (y0_d == '0);
  end

  // ---------------------------------------------------------------------------
  // valid bits and side items travel down one shift line
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q;
  side_t                 side_q [NUM_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NUM_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 1; k < NUM_STAGES; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stages 0 to 3: capture, magnitude, shift count, normalising shift
  // ---------------------------------------------------------------------------
  logic signed [VALUE_WIDTH-1:0] x0_q, y0_q;
  logic signed [VALUE_WIDTH-1:0] x1_q, y1_q;
  logic [VALUE_WIDTH-1:0]        m1_q;
  logic signed [VALUE_WIDTH-1:0] x2_q, y2_q;
  logic [SHIFT_W-1:0]            sh2_q;
  logic signed [NORM_W-1:0]      xn3_q, yn3_q;

  logic [VALUE_WIDTH-1:0] ax1_d, ay1_d;
  logic signed [NORM_W-1:0] xw2, yw2;

  // the or of both magnitudes has its top bit where the larger one has
  assign ax1_d = x0_q[VALUE_WIDTH-1] ? unsigned'(-x0_q) : unsigned'(x0_q);
  assign ay1_d = y0_q[VALUE_WIDTH-1] ? unsigned'(-y0_q) : unsigned'(y0_q);
  assign xw2   = {x2_q[VALUE_WIDTH-1], x2_q};
  assign yw2   = {y2_q[VALUE_WIDTH-1], y2_q};

  always_ff @(posedge clk_i) begin
    x0_q  <= x0_d;
    y0_q  <= y0_d;
    x1_q  <= x0_q;
    y1_q  <= y0_q;
    m1_q  <= ax1_d | ay1_d;
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    sh2_q <= norm_shift(m1_q);
    xn3_q <= xw2 <<< sh2_q;
    yn3_q <= yw2 <<< sh2_q;
  end

  // ---------------------------------------------------------------------------
  // stage 4: turn a left half plane vector by a quarter turn
  // ---------------------------------------------------------------------------
  logic signed [CORDIC_W-1:0] cx_q [ANGLE_ITERATIONS+1];
  logic signed [CORDIC_W-1:0] cy_q [ANGLE_ITERATIONS+1];
  logic signed [ANGLE_W-1:0]  cz_q [ANGLE_ITERATIONS+1];

  logic signed [CORDIC_W-1:0] xe4, ye4;
  assign xe4 = CORDIC_W'(xn3_q);
  assign ye4 = CORDIC_W'(yn3_q);

  always_ff @(posedge clk_i) begin
    if (!xe4[CORDIC_W-1]) begin
      cx_q[0] <= xe4;
      cy_q[0] <= ye4;
      cz_q[0] <= '0;
    end else if (!ye4[CORDIC_W-1]) begin
      cx_q[0] <= ye4;
      cy_q[0] <= -xe4;
      cz_q[0] <= HALF_PI_Q30;
    end else begin
      cx_q[0] <= -ye4;
      cy_q[0] <= xe4;
      cz_q[0] <= -HALF_PI_Q30;
    end
  end

  // ---------------------------------------------------------------------------
  // one vectoring micro-rotation per stage, driving y towards zero
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_iter
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANGLE_W-1:0]  ang;

    assign dx  = cy_q[i] >>> i;
    assign dy  = cx_q[i] >>> i;
    assign ang = atan_q30(5'(i));

    always_ff @(posedge clk_i) begin
      if (!cy_q[i][CORDIC_W-1]) begin
        cx_q[i+1] <= cx_q[i] + dx;
        cy_q[i+1] <= cy_q[i] - dy;
        cz_q[i+1] <= cz_q[i] + ang;
      end else begin
        cx_q[i+1] <= cx_q[i] - dx;
        cy_q[i+1] <= cy_q[i] + dy;
        cz_q[i+1] <= cz_q[i] - ang;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // last stage: round q30 to q16, saturate, place the angle, register the item
  // ---------------------------------------------------------------------------
  side_t                         side_l;
  logic signed [ANGLE_W-1:0]     z_rnd;
  logic signed [SAT_W-1:0]       z_ext;
  logic signed [SAT_W-1:0]       z_sat;
  logic signed [VALUE_WIDTH-1:0] angle;

  assign side_l = side_q[NUM_STAGES-1];
  assign z_rnd  = (cz_q[ANGLE_ITERATIONS] + ROUND_BIAS) >>> FRAC_DROP;
  assign z_ext  = SAT_W'(z_rnd);

  always_comb begin
    priority if (z_ext > SAT_HI) begin
      z_sat = SAT_HI;
    end else if (z_ext < SAT_LO) begin
      z_sat = SAT_LO;
    end else begin
      z_sat = z_ext;
    end
    angle = side_l.zero ? '0 : z_sat[VALUE_WIDTH-1:0];
  end

  logic                          done_q;
  logic signed [VALUE_WIDTH-1:0] out_a_q, out_b_q, out_c_q, out_d_q;
  logic [2:0]                    out_count_q;
  logic                          bad_kind_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    // the angle takes the slot that its joint kind names
    out_a_q     <= (side_l.dest == ANG_TO_A) ? angle : side_l.pa;
    out_c_q     <= (side_l.dest == ANG_TO_C) ? angle : side_l.pc;
    out_b_q     <= side_l.pb;
    out_d_q     <= side_l.pd;
    out_count_q <= side_l.count;
    bad_kind_q  <= side_l.bad;
    out_last_q  <= side_l.last;
  end

  assign done_o      = done_q;
  assign out_a_o     = out_a_q;
  assign out_b_o     = out_b_q;
  assign out_c_o     = out_c_q;
  assign out_d_o     = out_d_q;
  assign out_count_o = out_count_q;
  assign bad_kind_o  = bad_kind_q;
  assign out_last_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // every accepted item yields a strobe after the fixed latency
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted item produced no result");

  // no strobe without an item accepted the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without a matching item");

  // an unsupported kind gives an empty, all zero result
  a_bad_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_kind_o) |-> (out_count_o == 3'd0 && out_a_o == '0 &&
                                out_b_o == '0 && out_c_o == '0 && out_d_o == '0))
    else $error("unsupported kind with non-empty result");

  // the fourth value reads as zero whenever the count is three or less
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_count_o <= 3'd3) |-> (out_d_o == '0))
    else $error("unused value not cleared");

  // count never exceeds four values
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_count_o <= MAX_VALUES))
    else $error("result count out of range");
`endif

endmodule
